// ===== rtl/core/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_STOP  = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_READ  = 3'd3,
        MODE_SACK  = 3'd4,
        MODE_RACK  = 3'd5
    } mode_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
        logic       rejected;
    } out_t;

    localparam logic [7:0] RX_CLEAR = 8'h00;

    // Number of phase ticks per command
    function automatic logic [4:0] phase_len(input mode_t m);
        logic [4:0] len;
        begin
            case (m)
                MODE_START: len = 5'd4;
                MODE_STOP:  len = 5'd3;
                MODE_WRITE: len = 5'd24;
                MODE_READ:  len = 5'd25;
                MODE_SACK:  len = 5'd3;
                MODE_RACK:  len = 5'd4;
                default:    len = 5'd4;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/i2c_master_bit_engine_top.sv =====
// I2C master bit engine.
// s_ side: one transaction per bus phase tick, carrying an optional command
// (start, stop, write byte, read byte, send ack, receive ack) and the sampled
// SDA level. m_ side: one result transaction per tick with the SCL/SDA drive
// levels, busy, done, received byte/ack and a rejected flag.
// A command accepted while idle runs its first phase on that same tick; the
// following phases each take one further input transaction. Commands offered
// while busy, or with an unknown mode, are dropped and flagged as rejected.
// Each result is registered and shows on m_ side in the cycle after its input.
// Throughput: one transaction per cycle while results are taken; the phase
// step is a single register stage of small next-state logic feeding the
// output register. If the receiver stalls, the result is held in the output
// register and s_ready falls only while a held result is not being taken.
// Reset (aresetn low, synchronous): sequencer idle, both lines released,
// received ack set to one, no result pending.
module i2c_master_bit_engine_top
    import i2cmbe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    mode_t      cmd_reg, cmd_next;
    logic [4:0] phase_reg, phase_next;
    logic [1:0] sub_reg, sub_next;
    logic [2:0] bit_reg, bit_next;
    logic       run_reg, run_next;
    logic [7:0] tx_reg, tx_next;
    logic       ack_reg, ack_next;
    logic [7:0] rx_reg, rx_next;
    logic       acks_reg, acks_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       m_valid_reg;
    out_t       m_data_reg, m_data_next;
    logic       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        logic rejected;
        logic done;
        logic step_sub;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        bit_next   = bit_reg;
        run_next   = run_reg;
        tx_next    = tx_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        acks_next  = acks_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rejected   = 1'b0;
        done       = 1'b0;
        step_sub   = 1'b1;

        if (s_data.cmd_valid) begin
            if (run_reg || (s_data.mode > 3'(MODE_RACK))) begin
                rejected = 1'b1;
            end else begin
                cmd_next   = mode_t'(s_data.mode);
                phase_next = '0;
                sub_next   = '0;
                bit_next   = '0;
                run_next   = 1'b1;
                tx_next    = s_data.tx_byte;
                ack_next   = s_data.ack_out;
                if (s_data.mode == 3'(MODE_READ)) begin
                    rx_next = RX_CLEAR;
                end
            end
        end

        if (run_next) begin
            case (cmd_next)
                MODE_START: begin
                    case (phase_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                MODE_STOP: begin
                    case (phase_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                MODE_WRITE: begin
                    case (sub_next)
                        2'd0:    sda_next = tx_next[~bit_next];
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                MODE_READ: begin
                    if (phase_next == 5'd0) begin
                        // SDA release tick does not count towards the bit slots
                        sda_next = 1'b1;
                        step_sub = 1'b0;
                    end else begin
                        case (sub_next)
                            2'd0: scl_next = 1'b1;
                            2'd1: begin
                                if (s_data.sda_in) begin
                                    rx_next[~bit_next] = 1'b1;
                                end
                            end
                            default: scl_next = 1'b0;
                        endcase
                    end
                end
                MODE_SACK: begin
                    case (phase_next)
                        5'd0:    sda_next = ack_next;
                        5'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                default: begin
                    case (phase_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    acks_next = s_data.sda_in;
                        default: scl_next = 1'b0;
                    endcase
                end
            endcase

            if (step_sub) begin
                if (sub_next == 2'd2) begin
                    sub_next = '0;
                    bit_next = bit_next + 3'd1;
                end else begin
                    sub_next = sub_next + 2'd1;
                end
            end

            if ((6'(phase_next) + 6'd1) >= 6'(phase_len(cmd_next))) begin
                done       = 1'b1;
                run_next   = 1'b0;
                phase_next = '0;
            end else begin
                phase_next = phase_next + 5'd1;
            end
        end

        m_data_next.scl_level = scl_next;
        m_data_next.sda_level = sda_next;
        m_data_next.busy_res  = run_next;
        m_data_next.done_res  = done;
        m_data_next.rx_byte   = (done && (cmd_next == MODE_READ)) ? rx_next : 8'h00;
        m_data_next.rx_ack    = done && (cmd_next == MODE_RACK) && acks_next;
        m_data_next.rejected  = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg     <= MODE_START;
            phase_reg   <= '0;
            sub_reg     <= '0;
            bit_reg     <= '0;
            run_reg     <= 1'b0;
            tx_reg      <= '0;
            ack_reg     <= 1'b0;
            rx_reg      <= '0;
            acks_reg    <= 1'b1;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cmd_reg   <= cmd_next;
                phase_reg <= phase_next;
                sub_reg   <= sub_next;
                bit_reg   <= bit_next;
                run_reg   <= run_next;
                tx_reg    <= tx_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
                acks_reg  <= acks_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== rtl/core/i2cmbe_checker.sv =====
module i2cmbe_checker
    import i2cmbe_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // stalled result transaction must hold
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.busy_res)
        else $error("done with busy still set");

    a_rx_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.rx_byte != 8'h00) |-> m_data.done_res)
        else $error("received byte outside done");

    a_rx_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rx_ack |-> m_data.done_res)
        else $error("received ack outside done");

    // idle output stage always takes a new transaction
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready with empty output");

endmodule

bind i2c_master_bit_engine_top i2cmbe_checker u_i2cmbe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
